@@ hdl/iirdf1_pkg.sv @@
// Shared types, sizes and helpers for the direct-form-I IIR filter.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package iirdf1_pkg;

	localparam int TAPS        = 4;
	localparam int SAMPLE_BITS = 32;
	localparam int COEF_BITS   = 32;
	localparam int NCOEF       = 4;                 // b0..b3 and a0..a3 registers
	localparam int HIST_LEN    = TAPS - 1;
	// taps that have a coefficient register; the rest weigh zero
	localparam int NUSE        = (HIST_LEN < NCOEF - 1) ? HIST_LEN : NCOEF - 1;
	localparam int NTERMS      = 1 + 2 * NUSE;      // multiply-accumulates per item
	localparam int TERM_W      = $clog2(NTERMS);
	localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W       = PROD_W + $clog2(NTERMS) + 1;
	localparam int HIDX_W      = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
	localparam int PC_W        = $clog2(TAPS + 1);
	localparam int CP_W        = $clog2(TAPS);
	localparam int CNT_W       = $clog2(SAMPLE_BITS);

	// configuration register map
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_B_BASE  = 0;
	localparam int CFG_A_BASE  = NCOEF;
	localparam int CFG_END     = 2 * NCOEF;

	localparam logic [COEF_BITS-1:0] COEF_ONE = 32'h1000_0000;   // 1.0 in Q4.28

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [ACC_W-1:0]       acc_t;

	// one operand pair for the shared multiplier
	typedef struct packed {
		logic    vld;
		logic    first;   // start a new sum
		logic    sub;     // feedback term, subtract
		sample_t smp;
		coef_t   coef;
	} mac_op_t;

	// divider result, held until the next start
	typedef struct packed {
		logic    done;    // one-cycle pulse
		logic    sat;
		logic    dz;
		sample_t y;
	} div_res_t;

	// low 32 bits of a sign-extended sample
	function automatic logic [31:0] out_word(sample_t v);
		logic signed [63:0] t;
		t = 64'(v);
		return t[31:0];
	endfunction

	// low SAMPLE_BITS bits of the 32-bit port word
	function automatic sample_t in_sample(logic [31:0] d);
		logic [63:0] t;
		t = {32'd0, d};
		return sample_t'(t[SAMPLE_BITS-1:0]);
	endfunction

endpackage

`default_nettype wire

@@ hdl/iirdf1_mac.sv @@
// Shared multiply-accumulate unit of the IIR filter: registered product, then sum.
// Depends on iirdf1_pkg.
`default_nettype none

module iirdf1_mac (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire iirdf1_pkg::mac_op_t  op,
	output iirdf1_pkg::acc_t          acc
);

	logic signed [iirdf1_pkg::PROD_W-1:0] prod_s1;
	logic                                 vld_s1;
	logic                                 first_s1;
	logic                                 sub_s1;
	iirdf1_pkg::acc_t                     acc_q;
	iirdf1_pkg::acc_t                     term;
	iirdf1_pkg::acc_t                     base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= op.vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= $signed(op.smp) * $signed(op.coef);
		first_s1 <= op.first;
		sub_s1   <= op.sub;
	end

	always_comb begin
		term = sub_s1 ? -iirdf1_pkg::ACC_W'(prod_s1) : iirdf1_pkg::ACC_W'(prod_s1);
		base = first_s1 ? '0 : acc_q;
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= base + term;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

@@ hdl/iirdf1_div.sv @@
// Iterative signed divider with saturation: one quotient bit per cycle.
// Depends on iirdf1_pkg.
`default_nettype none

module iirdf1_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire iirdf1_pkg::acc_t     acc,
	input  wire iirdf1_pkg::coef_t    a0,
	output iirdf1_pkg::div_res_t      res
);

	localparam int SB = iirdf1_pkg::SAMPLE_BITS;
	localparam int HW = iirdf1_pkg::ACC_W - SB;

	typedef enum logic [3:0] {
		DV_IDLE  = 4'b0001,
		DV_CHECK = 4'b0010,
		DV_ITER  = 4'b0100,
		DV_FIN   = 4'b1000
	} dv_state_t;

	dv_state_t                       st_q;
	logic [iirdf1_pkg::ACC_W-1:0]    mag_q;
	logic [31:0]                     d_q;
	logic                            neg_q;
	logic                            dz_q;
	logic [31:0]                     rem_q;
	logic [SB-1:0]                   dvd_q;
	logic [iirdf1_pkg::CNT_W-1:0]    cnt_q;
	iirdf1_pkg::div_res_t            res_q;

	logic [HW-1:0]                   hi;
	logic [32:0]                     cur;
	logic [32:0]                     dext;
	logic                            ge;
	logic                            over;
	iirdf1_pkg::sample_t             sat_val;
	iirdf1_pkg::sample_t             q_val;

	always_comb begin
		hi      = mag_q[iirdf1_pkg::ACC_W-1:SB];
		cur     = {rem_q, dvd_q[SB-1]};
		dext    = {1'b0, d_q};
		ge      = (cur >= dext);
		// magnitude above the range: at the positive end, anything with the top bit set
		over    = dvd_q[SB-1] & (~neg_q | (|dvd_q[SB-2:0]));
		sat_val = neg_q ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
		q_val   = neg_q ? -$signed(dvd_q) : $signed(dvd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= DV_IDLE;
			res_q <= '0;
			mag_q <= '0;
			d_q   <= '0;
			neg_q <= 1'b0;
			dz_q  <= 1'b0;
			rem_q <= '0;
			dvd_q <= '0;
			cnt_q <= '0;
		end else begin
			res_q.done <= 1'b0;
			case (st_q)
				DV_IDLE: begin
					if (start) begin
						mag_q <= acc[iirdf1_pkg::ACC_W-1] ? -acc : acc;
						d_q   <= a0[31] ? (~a0 + 32'd1) : a0;
						neg_q <= acc[iirdf1_pkg::ACC_W-1] ^ a0[31];
						dz_q  <= (a0 == '0);
						st_q  <= DV_CHECK;
					end
				end
				DV_CHECK: begin
					if (dz_q) begin
						res_q <= '{done: 1'b1, sat: 1'b0, dz: 1'b1, y: '0};
						st_q  <= DV_IDLE;
					end else if (hi >= HW'(d_q)) begin
						// quotient has bits above the sample width
						res_q <= '{done: 1'b1, sat: 1'b1, dz: 1'b0, y: sat_val};
						st_q  <= DV_IDLE;
					end else begin
						rem_q <= hi[31:0];
						dvd_q <= mag_q[SB-1:0];
						cnt_q <= iirdf1_pkg::CNT_W'(SB - 1);
						st_q  <= DV_ITER;
					end
				end
				DV_ITER: begin
					rem_q <= ge ? 32'(cur - dext) : cur[31:0];
					dvd_q <= {dvd_q[SB-2:0], ge};
					if (cnt_q == '0) begin
						st_q <= DV_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				DV_FIN: begin
					res_q <= '{done: 1'b1, sat: over, dz: 1'b0, y: over ? sat_val : q_val};
					st_q  <= DV_IDLE;
				end
				default: begin
					st_q <= DV_IDLE;
				end
			endcase
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

@@ hdl/iir_filter_direct_form1.sv @@
// Top level of the direct-form-I IIR filter: coefficient registers, histories, sequencer.
// Depends on iirdf1_pkg, iirdf1_mac and iirdf1_div.
`default_nettype none

// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: sample_in; tlast: record_end
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: sample_out; tuser: saturated,
//                                                     divisor_zero; tlast: run_last
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data (always ready)
//
// An item that only primes the history is taken in ST_IDLE and yields no result. A
// filtered item runs its multiply-accumulates on the one shared multiplier, then the
// iterative divide; the first full item of a record also sends priming copies. A new
// item is accepted only once the last one is back in ST_IDLE. A zero a0 or a quotient
// that overflows early skips the divider loop.
// Reset clears the coefficients to their defaults and the histories to zero.
// A stalled output delays only priming copies and the final result; the output
// register lets the next item in while the last result waits.

module iir_filter_direct_form1 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input samples
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] sample_in
	input  wire logic        s_axis_tlast,   // record_end
	// results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [31:0] sample_out
	output logic [1:0]       m_axis_tuser,   // [0] saturated, [1] divisor_zero
	output logic             m_axis_tlast,   // run_last
	// coefficient writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int HL = iirdf1_pkg::HIST_LEN;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PRIME = 7'b0000010,
		ST_MAC   = 7'b0000100,
		ST_DRAIN = 7'b0001000,
		ST_START = 7'b0010000,
		ST_DIV   = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t                             st_q;
	iirdf1_pkg::coef_t                  coef_b_q [iirdf1_pkg::NCOEF];
	iirdf1_pkg::coef_t                  coef_a_q [iirdf1_pkg::NCOEF];
	iirdf1_pkg::sample_t                ih_q     [HL];   // past inputs, newest first
	iirdf1_pkg::sample_t                oh_q     [HL];   // past outputs, newest first
	logic [iirdf1_pkg::PC_W-1:0]        pc_q;            // samples seen, saturates at TAPS
	logic [iirdf1_pkg::CP_W-1:0]        copy_q;          // priming copies still to send after the current one
	logic [iirdf1_pkg::TERM_W-1:0]      term_q;
	iirdf1_pkg::sample_t                x_q;
	logic                               end_q;

	// output register
	logic                               out_vld_q;
	logic [31:0]                        out_data_q;
	logic                               out_sat_q;
	logic                               out_dz_q;
	logic                               out_last_q;

	iirdf1_pkg::mac_op_t                mac_op;
	iirdf1_pkg::acc_t                   acc;
	iirdf1_pkg::div_res_t               div_res;
	logic                               div_start;

	logic                               in_acc;
	logic                               out_free;
	iirdf1_pkg::sample_t                x_in;
	logic [iirdf1_pkg::TERM_W-1:0]      jw;
	logic [1:0]                         j;
	logic [1:0]                         jm1;
	logic [iirdf1_pkg::HIDX_W-1:0]      hidx;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign out_free      = ~out_vld_q | m_axis_tready;
	assign x_in          = iirdf1_pkg::in_sample(s_axis_tdata);
	assign div_start     = (st_q == ST_START);

	// term 0 is b0*x; odd terms b_j*x[n-j]; even terms a_j*y[n-j], subtracted
	always_comb begin
		jw   = iirdf1_pkg::TERM_W'(term_q + 1'b1);
		j    = 2'(jw >> 1);
		jm1  = j - 2'd1;
		hidx = iirdf1_pkg::HIDX_W'(jm1);
		mac_op.vld   = (st_q == ST_MAC);
		mac_op.first = (term_q == '0);
		if (term_q == '0) begin
			mac_op.sub  = 1'b0;
			mac_op.smp  = x_q;
			mac_op.coef = coef_b_q[0];
		end else if (term_q[0]) begin
			mac_op.sub  = 1'b0;
			mac_op.smp  = ih_q[hidx];
			mac_op.coef = coef_b_q[j];
		end else begin
			mac_op.sub  = 1'b1;
			mac_op.smp  = oh_q[hidx];
			mac_op.coef = coef_a_q[j];
		end
	end

	iirdf1_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mac_op),
		.acc    (acc)
	);

	iirdf1_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.acc    (acc),
		.a0     (coef_a_q[0]),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			for (int i = 0; i < iirdf1_pkg::NCOEF; i++) begin
				coef_b_q[i] <= '0;
				coef_a_q[i] <= '0;
			end
			coef_b_q[0] <= iirdf1_pkg::COEF_ONE;
			coef_a_q[0] <= iirdf1_pkg::COEF_ONE;
			for (int i = 0; i < HL; i++) begin
				ih_q[i] <= '0;
				oh_q[i] <= '0;
			end
			pc_q       <= '0;
			copy_q     <= '0;
			term_q     <= '0;
			x_q        <= '0;
			end_q      <= 1'b0;
			out_vld_q  <= 1'b0;
			out_data_q <= '0;
			out_sat_q  <= 1'b0;
			out_dz_q   <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (out_vld_q && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end

			// coefficient writes; indexes past the map are dropped
			if (cfg_valid) begin
				if (cfg_index < iirdf1_pkg::CFG_IDX_W'(iirdf1_pkg::CFG_A_BASE)) begin
					coef_b_q[2'(cfg_index - iirdf1_pkg::CFG_IDX_W'(iirdf1_pkg::CFG_B_BASE))]
						<= cfg_data;
				end else if (cfg_index < iirdf1_pkg::CFG_IDX_W'(iirdf1_pkg::CFG_END)) begin
					coef_a_q[2'(cfg_index - iirdf1_pkg::CFG_IDX_W'(iirdf1_pkg::CFG_A_BASE))]
						<= cfg_data;
				end
			end

			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						x_q   <= x_in;
						end_q <= s_axis_tlast;
						if (pc_q < iirdf1_pkg::PC_W'(HL)) begin
							// still priming: history only, no result
							ih_q[0] <= x_in;
							for (int i = 1; i < HL; i++) begin
								ih_q[i] <= ih_q[i-1];
							end
							pc_q <= pc_q + 1'b1;
							if (s_axis_tlast) begin
								// short record
								for (int i = 0; i < HL; i++) begin
									ih_q[i] <= '0;
									oh_q[i] <= '0;
								end
								pc_q <= '0;
							end
						end else if (pc_q == iirdf1_pkg::PC_W'(HL)) begin
							// first full item: output history takes the sample
							for (int i = 0; i < HL; i++) begin
								oh_q[i] <= x_in;
							end
							pc_q   <= iirdf1_pkg::PC_W'(iirdf1_pkg::TAPS);
							copy_q <= iirdf1_pkg::CP_W'(HL - 1);
							st_q   <= ST_PRIME;
						end else begin
							term_q <= '0;
							st_q   <= ST_MAC;
						end
					end
				end
				ST_PRIME: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_data_q <= iirdf1_pkg::out_word(x_q);
						out_sat_q  <= 1'b0;
						out_dz_q   <= 1'b0;
						out_last_q <= 1'b0;
						if (copy_q == '0) begin
							term_q <= '0;
							st_q   <= ST_MAC;
						end else begin
							copy_q <= copy_q - 1'b1;
						end
					end
				end
				ST_MAC: begin
					if (term_q == iirdf1_pkg::TERM_W'(iirdf1_pkg::NTERMS - 1)) begin
						st_q <= ST_DRAIN;
					end else begin
						term_q <= term_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// last product enters the sum
					st_q <= ST_START;
				end
				ST_START: begin
					st_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_res.done) begin
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_data_q <= iirdf1_pkg::out_word(div_res.y);
						out_sat_q  <= div_res.sat;
						out_dz_q   <= div_res.dz;
						out_last_q <= 1'b1;
						oh_q[0] <= div_res.y;
						ih_q[0] <= x_q;
						for (int i = 1; i < HL; i++) begin
							oh_q[i] <= oh_q[i-1];
							ih_q[i] <= ih_q[i-1];
						end
						if (end_q) begin
							for (int i = 0; i < HL; i++) begin
								ih_q[i] <= '0;
								oh_q[i] <= '0;
							end
							pc_q <= '0;
						end
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = {out_dz_q, out_sat_q};
	assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
